/* rtl/kwms_pkg.sv */
// ----------------------------------------------------------------------------
// kwms_pkg
// Shared types and constants for the k-way merge select block.
// ----------------------------------------------------------------------------
package kwms_pkg;

    localparam int MAX_RUNS      = 16;
    localparam int RUN_IDX_W     = $clog2(MAX_RUNS);
    localparam int RUN_CNT_W     = $clog2(MAX_RUNS + 1);
    localparam int ELEMENT_WIDTH = 32;

    // stream data width: run index plus element, padded to whole bytes
    localparam int TDATA_W = ((RUN_IDX_W + ELEMENT_WIDTH + 7) / 8) * 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS = 1'd1;
    localparam int CFG_DATA_W = 5;

    // input mode codes
    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_SUPPLY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } seq_state_t;

    // sequencer to compare unit
    typedef struct packed {
        logic                 clear;
        logic                 step;
        logic [RUN_IDX_W-1:0] idx;
        logic                 live;
    } scan_ctrl_t;

endpackage

/* rtl/kwms_head_mem.sv */
// ----------------------------------------------------------------------------
// kwms_head_mem
// Head element store, one entry per run, registered read port.
// ----------------------------------------------------------------------------
module kwms_head_mem
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [kwms_pkg::RUN_IDX_W-1:0]       wr_addr,
    input  logic [kwms_pkg::ELEMENT_WIDTH-1:0]   wr_data,
    input  logic                                 rd_en,
    input  logic [kwms_pkg::RUN_IDX_W-1:0]       rd_addr,
    output logic [kwms_pkg::ELEMENT_WIDTH-1:0]   rd_data
);

    logic [kwms_pkg::ELEMENT_WIDTH-1:0] mem [kwms_pkg::MAX_RUNS];
    logic [kwms_pkg::ELEMENT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/kwms_scan.sv */
// ----------------------------------------------------------------------------
// kwms_scan
// Shared key comparator with running best head and best run index.
// ----------------------------------------------------------------------------
module kwms_scan
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kwms_pkg::scan_ctrl_t                 ctrl,
    input  logic                                 signed_keys,
    input  logic [kwms_pkg::ELEMENT_WIDTH-1:0]   rd_data,
    output logic [kwms_pkg::ELEMENT_WIDTH-1:0]   best_val,
    output logic [kwms_pkg::RUN_IDX_W-1:0]       best_idx
);

    logic                               step_d_reg;
    logic                               live_d_reg;
    logic [kwms_pkg::RUN_IDX_W-1:0]     idx_d_reg;
    logic                               found_reg;
    logic [kwms_pkg::ELEMENT_WIDTH-1:0] best_val_reg;
    logic [kwms_pkg::RUN_IDX_W-1:0]     best_idx_reg;

    logic [kwms_pkg::ELEMENT_WIDTH-1:0] sign_flip;
    logic                               best_greater;
    logic                               take;

    // signed order = unsigned order with the sign bit flipped
    assign sign_flip    = {signed_keys, {(kwms_pkg::ELEMENT_WIDTH-1){1'b0}}};
    assign best_greater = (best_val_reg ^ sign_flip) > (rd_data ^ sign_flip);
    // strict compare keeps the lower index on ties
    assign take         = step_d_reg && live_d_reg && (!found_reg || best_greater);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_d_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            step_d_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            step_d_reg <= ctrl.step;
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        live_d_reg <= ctrl.live;
        idx_d_reg  <= ctrl.idx;
        if (take)
        begin
            best_val_reg <= rd_data;
            best_idx_reg <= idx_d_reg;
        end
    end

    assign best_val = best_val_reg;
    assign best_idx = best_idx_reg;

endmodule

/* rtl/kway_merge_select.sv */
// ----------------------------------------------------------------------------
// kway_merge_select
// K-way merge engine: picks the smallest live run head by a linear scan.
// ----------------------------------------------------------------------------
// Usage: send a restart transaction (s_tuser[0] = 0), then one supply
// transaction per run (s_tuser[0] = 1) giving its first element or marking it
// exhausted (s_tuser[1]). Once run_count supplies are in, every supply yields
// one result: the smallest live head with the run to refill next (ties go to
// the lower run), or a done result (m_tuser = 1, data zero) when no run below
// run_count is live. Supplies for runs at or above run_count are dropped.
// Sequence: an input transaction that ends the fill phase or refills a run
// passes through the accept, scan, drain and emit states in that order; the
// scan runs one head per cycle through a single comparator fed by the one
// read port of the head store. A restart or a fill supply is taken in idle
// alone; a done result skips the scan and drain states. The input is held
// off (s_tready low) until the block is back in idle; a result waiting at
// the output register stalls only the next result.
// ----------------------------------------------------------------------------
module kway_merge_select
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [kwms_pkg::TDATA_W-1:0]         s_tdata,  // run_index[3:0], element[35:4], zero pad
    input  logic [1:0]                           s_tuser,  // mode[0], exhausted[1]

    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [kwms_pkg::TDATA_W-1:0]         m_tdata,  // element_out[31:0], refill_run[35:32], zero pad
    output logic [0:0]                           m_tuser,  // done_res[0]

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [kwms_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kwms_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int RW = kwms_pkg::RUN_IDX_W;
    localparam int CW = kwms_pkg::RUN_CNT_W;
    localparam int EW = kwms_pkg::ELEMENT_WIDTH;

    // input fields
    logic          in_mode;
    logic          in_exhausted;
    logic [RW-1:0] in_run;
    logic [EW-1:0] in_elem;

    assign in_mode      = s_tuser[0];
    assign in_exhausted = s_tuser[1];
    assign in_run       = s_tdata[RW-1:0];
    assign in_elem      = s_tdata[RW+EW-1:RW];

    // configuration
    logic [CW-1:0] run_count_reg;
    logic          signed_keys_reg;

    // merge state
    kwms_pkg::seq_state_t              state_reg, state_next;
    logic [kwms_pkg::MAX_RUNS-1:0]     live_reg;
    logic [CW-1:0]                     fill_reg;
    logic [RW-1:0]                     scan_idx_reg;
    logic                              done_pend_reg;

    // output register
    logic          out_valid_reg;
    logic [EW-1:0] out_elem_reg;
    logic [RW-1:0] out_run_reg;
    logic          out_done_reg;

    // accept-time decode
    logic                          in_xfer;
    logic                          in_ok;
    logic [kwms_pkg::MAX_RUNS-1:0] live_upd;
    logic [kwms_pkg::MAX_RUNS-1:0] run_mask;
    logic                          any_live;
    logic [CW-1:0]                 fill_inc;
    logic                          gives_result;
    logic                          scan_last;
    logic                          out_free;

    // sequencer outputs
    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic                  out_load;
    kwms_pkg::scan_ctrl_t  scan_ctrl;

    logic [EW-1:0] rd_data;
    logic [EW-1:0] best_val;
    logic [RW-1:0] best_idx;

    assign in_xfer  = s_tvalid && s_tready;
    assign in_ok    = (in_mode == kwms_pkg::MODE_SUPPLY) && ({1'b0, in_run} < run_count_reg);
    assign fill_inc = fill_reg + CW'(1);
    assign out_free = !out_valid_reg || m_tready;
    assign scan_last = ({1'b0, scan_idx_reg} == (run_count_reg - CW'(1)));

    always_comb
    begin
        live_upd         = live_reg;
        live_upd[in_run] = !in_exhausted;
        for (int i = 0; i < kwms_pkg::MAX_RUNS; i++)
        begin
            run_mask[i] = (CW'(i) < run_count_reg);
        end
    end

    assign any_live     = |(live_upd & run_mask);
    // first result comes with the supply that completes the fill phase
    assign gives_result = (fill_reg >= run_count_reg) || (fill_inc >= run_count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kwms_pkg::ST_IDLE:
            begin
                if (in_xfer && in_ok && gives_result)
                begin
                    state_next = any_live ? kwms_pkg::ST_SCAN : kwms_pkg::ST_EMIT;
                end
            end
            kwms_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = kwms_pkg::ST_DRAIN;
                end
            end
            kwms_pkg::ST_DRAIN:
            begin
                state_next = kwms_pkg::ST_EMIT;
            end
            kwms_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = kwms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kwms_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready        = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        out_load        = 1'b0;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.step  = 1'b0;
        scan_ctrl.idx   = scan_idx_reg;
        scan_ctrl.live  = live_reg[scan_idx_reg];
        case (state_reg)
            kwms_pkg::ST_IDLE:
            begin
                s_tready        = 1'b1;
                mem_wr_en       = in_xfer && in_ok && !in_exhausted;
                scan_ctrl.clear = in_xfer;
            end
            kwms_pkg::ST_SCAN:
            begin
                mem_rd_en      = 1'b1;
                scan_ctrl.step = 1'b1;
            end
            kwms_pkg::ST_DRAIN:
            begin
            end
            kwms_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kwms_pkg::ST_IDLE;
            live_reg        <= '0;
            fill_reg        <= '0;
            scan_idx_reg    <= '0;
            done_pend_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            run_count_reg   <= CW'(kwms_pkg::MAX_RUNS);
            signed_keys_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration, the user is to write it while idle; the block does not enforce it
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    kwms_pkg::CFG_RUN_COUNT:
                    begin
                        if (cfg_data == '0)
                        begin
                            run_count_reg <= CW'(1);
                        end
                        else if (CW'(cfg_data) > CW'(kwms_pkg::MAX_RUNS))
                        begin
                            run_count_reg <= CW'(kwms_pkg::MAX_RUNS);
                        end
                        else
                        begin
                            run_count_reg <= CW'(cfg_data);
                        end
                    end
                    kwms_pkg::CFG_SIGNED_KEYS:
                    begin
                        signed_keys_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            // item accept
            if (in_xfer)
            begin
                scan_idx_reg <= '0;
                if (in_mode == kwms_pkg::MODE_RESTART)
                begin
                    live_reg <= '0;
                    fill_reg <= '0;
                end
                else if (in_ok)
                begin
                    live_reg      <= live_upd;
                    done_pend_reg <= !any_live;
                    if (fill_reg < run_count_reg)
                    begin
                        fill_reg <= fill_inc;
                    end
                end
            end

            if (state_reg == kwms_pkg::ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + RW'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_done_reg <= done_pend_reg;
            out_elem_reg <= done_pend_reg ? '0 : best_val;
            out_run_reg  <= done_pend_reg ? '0 : best_idx;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(kwms_pkg::TDATA_W-RW-EW){1'b0}}, out_run_reg, out_elem_reg};
    assign m_tuser   = out_done_reg;

    kwms_head_mem u_head_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (in_run),
        .wr_data (in_elem),
        .rd_en   (mem_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    kwms_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (scan_ctrl),
        .signed_keys (signed_keys_reg),
        .rd_data     (rd_data),
        .best_val    (best_val),
        .best_idx    (best_idx)
    );

    // restart leaves no live run behind
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_mode == kwms_pkg::MODE_RESTART) |=> (live_reg == '0 && fill_reg == '0))
        else $error("restart did not clear merge state");

    // scan pointer never passes the configured run count
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kwms_pkg::ST_SCAN) |-> ({1'b0, scan_idx_reg} < run_count_reg))
        else $error("scan index beyond run count");

    // done result carries no element
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_elem_reg == '0 && out_run_reg == '0))
        else $error("done result with nonzero payload");

    // fill counter never exceeds the largest run count
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(kwms_pkg::MAX_RUNS))
        else $error("fill count overflow");

endmodule
